/* rtl/core/wfp_pkg.sv */
// ----------------------------------------------------------------------------
// WebSocket frame parser package
// Shared types and constants for the frame parser front end, the word queue
// and the result stage.
// ----------------------------------------------------------------------------
package wfp_pkg;

	// Length codes that announce an extended length field.
	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;

	// Byte value that leaves a payload byte unchanged under the mask.
	localparam logic [7:0] NO_KEY = 8'h00;

	// Depth of the queue between the parser and the result stage.
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	// Result status codes.
	typedef enum logic [1:0] {
		ST_HEADER   = 2'd0,
		ST_PAYLOAD  = 2'd1,
		ST_RESERVED = 2'd2,
		ST_REJECT   = 2'd3
	} wfp_status_t;

	// One classified word as it leaves the parser: the payload byte is still
	// masked and travels with the key byte that undoes the mask.
	typedef struct packed {
		wfp_status_t status;
		logic [7:0]  data;
		logic [7:0]  key;
		logic        frame_done;
		logic        fin;
		logic [3:0]  opcode;
		logic        masked;
		logic [63:0] frame_len;
	} wfp_word_t;

	// Queue status seen by the parser and the result stage.
	typedef struct packed {
		logic full;
		logic not_empty;
	} wfp_qstat_t;

endpackage

/* rtl/core/wfp_front.sv */
// ----------------------------------------------------------------------------
// WebSocket frame parser front end
// Takes one stream byte per word, walks the header, extended length and
// masking key, and classifies each byte into a word for the queue.
// ----------------------------------------------------------------------------
module wfp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [7:0]       data_byte,
	input  logic             start_frame,
	output wfp_pkg::wfp_word_t word
);
	import wfp_pkg::*;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_LENGTH,
		PH_MASK,
		PH_PAYLOAD,
		PH_DONE,
		PH_ERROR
	} phase_t;

	phase_t      phase_q, phase_d, phase_c;
	logic        hdr_cnt_q, hdr_cnt_d, hdr_cnt_c;
	logic        fin_q, fin_d, fin_c;
	logic [3:0]  opcode_q, opcode_d, opcode_c;
	logic        mask_q, mask_d, mask_c;
	logic        len16_q, len16_d, len16_c;
	logic [2:0]  ext_cnt_q, ext_cnt_d, ext_cnt_c;
	logic [63:0] flen_q, flen_d, flen_c;
	logic [63:0] left_q, left_d, left_c;
	logic [63:0] left_dec;
	logic [31:0] key_q, key_d, key_c;
	logic [1:0]  kidx_q, kidx_d, kidx_c;
	logic        rsv_q, rsv_d, rsv_c;
	logic [6:0]  len_code;
	logic [7:0]  key_byte;
	logic        ext_last;
	logic        done;
	wfp_status_t status;
	logic [7:0]  pay_byte;
	logic [7:0]  pay_key;

	// A start mark sees the parser as if just reset.
	always_comb begin
		if (start_frame) begin
			phase_c   = PH_HEADER;
			hdr_cnt_c = 1'b0;
			fin_c     = 1'b0;
			opcode_c  = '0;
			mask_c    = 1'b0;
			len16_c   = 1'b0;
			ext_cnt_c = '0;
			flen_c    = '0;
			left_c    = '0;
			key_c     = '0;
			kidx_c    = '0;
			rsv_c     = 1'b0;
		end else begin
			phase_c   = phase_q;
			hdr_cnt_c = hdr_cnt_q;
			fin_c     = fin_q;
			opcode_c  = opcode_q;
			mask_c    = mask_q;
			len16_c   = len16_q;
			ext_cnt_c = ext_cnt_q;
			flen_c    = flen_q;
			left_c    = left_q;
			key_c     = key_q;
			kidx_c    = kidx_q;
			rsv_c     = rsv_q;
		end
	end

	// Helpers for the byte at hand.
	assign len_code = data_byte[6:0];
	assign left_dec = left_c - 64'd1;
	assign ext_last = len16_c ? (ext_cnt_c == 3'd1) : (ext_cnt_c == 3'd7);

	always_comb begin
		unique case (kidx_c)
			2'd0: key_byte = key_c[31:24];
			2'd1: key_byte = key_c[23:16];
			2'd2: key_byte = key_c[15:8];
			default: key_byte = key_c[7:0];
		endcase
	end

	// Next state and classification of the byte.
	always_comb begin
		phase_d   = phase_c;
		hdr_cnt_d = hdr_cnt_c;
		fin_d     = fin_c;
		opcode_d  = opcode_c;
		mask_d    = mask_c;
		len16_d   = len16_c;
		ext_cnt_d = ext_cnt_c;
		flen_d    = flen_c;
		left_d    = left_c;
		key_d     = key_c;
		kidx_d    = kidx_c;
		rsv_d     = rsv_c;
		status    = ST_HEADER;
		done      = 1'b0;
		pay_byte  = 8'h00;
		pay_key   = NO_KEY;
		unique case (phase_c)
			PH_HEADER: begin
				if (!hdr_cnt_c) begin
					fin_d     = data_byte[7];
					rsv_d     = (data_byte[6:4] != 3'd0);
					opcode_d  = data_byte[3:0];
					hdr_cnt_d = 1'b1;
				end else begin
					hdr_cnt_d = 1'b0;
					mask_d    = data_byte[7];
					len16_d   = (len_code == LEN_CODE_16);
					if (rsv_c) begin
						status  = ST_RESERVED;
						phase_d = PH_ERROR;
					end else if (len_code == LEN_CODE_16 || len_code == LEN_CODE_64) begin
						flen_d    = '0;
						ext_cnt_d = '0;
						phase_d   = PH_LENGTH;
					end else begin
						flen_d = {57'd0, len_code};
						left_d = {57'd0, len_code};
						kidx_d = '0;
						if (data_byte[7]) begin
							phase_d = PH_MASK;
						end else if (len_code == 7'd0) begin
							phase_d = PH_DONE;
							done    = 1'b1;
						end else begin
							phase_d = PH_PAYLOAD;
						end
					end
				end
			end
			PH_LENGTH: begin
				flen_d = {flen_c[55:0], data_byte};
				if (ext_last) begin
					ext_cnt_d = '0;
					left_d    = {flen_c[55:0], data_byte};
					kidx_d    = '0;
					if (mask_c) begin
						phase_d = PH_MASK;
					end else if ({flen_c[55:0], data_byte} == 64'd0) begin
						phase_d = PH_DONE;
						done    = 1'b1;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end else begin
					ext_cnt_d = ext_cnt_c + 3'd1;
				end
			end
			PH_MASK: begin
				key_d = {key_c[23:0], data_byte};
				if (kidx_c == 2'd3) begin
					kidx_d = '0;
					if (left_c == 64'd0) begin
						phase_d = PH_DONE;
						done    = 1'b1;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end else begin
					kidx_d = kidx_c + 2'd1;
				end
			end
			PH_PAYLOAD: begin
				status   = ST_PAYLOAD;
				pay_byte = data_byte;
				pay_key  = mask_c ? key_byte : NO_KEY;
				kidx_d   = kidx_c + 2'd1;
				left_d   = left_dec;
				if (left_dec == 64'd0) begin
					phase_d = PH_DONE;
					done    = 1'b1;
				end
			end
			default: begin
				status  = ST_REJECT;
				phase_d = PH_ERROR;
			end
		endcase
	end

	// Word handed to the queue.
	always_comb begin
		word.status     = status;
		word.data       = pay_byte;
		word.key        = pay_key;
		word.frame_done = done;
		word.fin        = fin_d;
		word.opcode     = opcode_d;
		word.masked     = mask_d;
		word.frame_len  = flen_d;
	end

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_cnt_q <= 1'b0;
			fin_q     <= 1'b0;
			opcode_q  <= '0;
			mask_q    <= 1'b0;
			len16_q   <= 1'b0;
			ext_cnt_q <= '0;
			flen_q    <= '0;
			left_q    <= '0;
			key_q     <= '0;
			kidx_q    <= '0;
			rsv_q     <= 1'b0;
		end else if (take) begin
			phase_q   <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			fin_q     <= fin_d;
			opcode_q  <= opcode_d;
			mask_q    <= mask_d;
			len16_q   <= len16_d;
			ext_cnt_q <= ext_cnt_d;
			flen_q    <= flen_d;
			left_q    <= left_d;
			key_q     <= key_d;
			kidx_q    <= kidx_d;
			rsv_q     <= rsv_d;
		end
	end

endmodule

/* rtl/core/wfp_queue.sv */
// ----------------------------------------------------------------------------
// WebSocket frame parser word queue
// Short first-in first-out queue that decouples the parser from the result
// stage.
// ----------------------------------------------------------------------------
module wfp_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  wfp_pkg::wfp_word_t wr_word,
	input  logic               rd_en,
	output wfp_pkg::wfp_word_t rd_word,
	output wfp_pkg::wfp_qstat_t qstat
);
	import wfp_pkg::*;

	wfp_word_t            slots_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_PTR_W:0]     count_q;

	assign qstat.full      = (count_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign qstat.not_empty = (count_q != '0);
	assign rd_word         = slots_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots_q[wr_ptr_q] <= wr_word;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + (Q_PTR_W+1)'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - (Q_PTR_W+1)'(1);
			end
		end
	end

endmodule

/* rtl/core/wfp_back.sv */
// ----------------------------------------------------------------------------
// WebSocket frame parser result stage
// Unmasks payload bytes and holds the oldest result until it is popped.
// ----------------------------------------------------------------------------
module wfp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  wfp_pkg::wfp_qstat_t qstat,
	input  wfp_pkg::wfp_word_t  rd_word,
	output logic                rd_en,
	input  logic                pop,
	output logic                empty,
	output wfp_pkg::wfp_word_t  result
);
	import wfp_pkg::*;

	logic      valid_q;
	wfp_word_t res_q;
	wfp_word_t load_word;
	logic      load;

	// Refill the output register when it is free or being drained.
	assign load   = qstat.not_empty && (!valid_q || pop);
	assign rd_en  = load;
	assign empty  = !valid_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	// Payload bytes leave with the mask removed.
	always_comb begin
		load_word      = rd_word;
		load_word.data = rd_word.data ^ rd_word.key;
		load_word.key  = NO_KEY;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= load_word;
		end
	end

endmodule

/* rtl/core/websocket_frame_parser.sv */
// ----------------------------------------------------------------------------
// WebSocket frame parser
// Parses a WebSocket byte stream one byte per word and streams out results.
//
// Input side is a queue write port: a word (data_byte, start_frame) is taken
// at a clock edge where push is high and full is low. Output side is a queue
// read port: while empty is low the oldest result is on status, data_out,
// frame_done, fin, opcode, masked and frame_len, and it is taken at an
// edge where pop is high. Every input word yields exactly one result.
// A taken word passes through the queue into the result register. The parser
// takes one word per cycle while full is low; the result register refills in
// the cycle it is popped, so while the queue holds words and pop stays high,
// one result per cycle leaves. When the receiver stalls, the four-word queue
// absorbs words; full rises once it and the result register hold five results
// in all. Reset empties the queue and the result register and puts the parser
// back at the first header byte with all fields zero.
// ----------------------------------------------------------------------------
module websocket_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        start_frame,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic [7:0]  data_out,
	output logic        frame_done,
	output logic        fin,
	output logic [3:0]  opcode,
	output logic        masked,
	output logic [63:0] frame_len
);
	import wfp_pkg::*;

	wfp_word_t  fr_word;
	wfp_word_t  q_word;
	wfp_word_t  result;
	wfp_qstat_t qstat;
	logic       take;
	logic       rd_en;

	assign full = qstat.full;
	assign take = push && !qstat.full;

	// Parser.
	wfp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.data_byte   (data_byte),
		.start_frame (start_frame),
		.word        (fr_word)
	);

	// Queue between the parser and the result stage.
	wfp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (take),
		.wr_word (fr_word),
		.rd_en   (rd_en),
		.rd_word (q_word),
		.qstat   (qstat)
	);

	// Result stage.
	wfp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.qstat   (qstat),
		.rd_word (q_word),
		.rd_en   (rd_en),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

	assign status     = result.status;
	assign data_out   = result.data;
	assign frame_done = result.frame_done;
	assign fin        = result.fin;
	assign opcode     = result.opcode;
	assign masked     = result.masked;
	assign frame_len  = result.frame_len;

endmodule

/* verif/websocket_frame_parser_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame parser testbench
// Feeds byte streams through the parser's queue ports and checks every result
// against its typed row or an in-bench model of RFC 6455 header and unmasking
// logic. A short directed table comes first, then mostly well-formed random
// frames mixed with truncated frames, reserved-bit errors and stray bytes.
// ----------------------------------------------------------------------------
module websocket_frame_parser_tb;
	import wfp_pkg::*;

	// Expected content of one result word.
	typedef struct packed {
		wfp_status_t st;
		logic [7:0]  data;
		logic        done;
		logic        fin;
		logic [3:0]  op;
		logic        masked;
		logic [63:0] len;
	} frame_result_t;

	// One row of the directed table; typed rows carry their own expectation.
	typedef struct packed {
		logic [7:0]    b;
		logic          start;
		logic          typed;
		frame_result_t want;
	} stim_row_t;

	typedef enum {
		P_HEADER, P_LENGTH, P_KEY, P_PAYLOAD, P_DONE, P_FAILED
	} parse_phase_t;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_WORDS = 1250;
	localparam int HOLD_CYCLES = 60;

	localparam frame_result_t UNTYPED = '{ST_HEADER, 8'h00, 1'b0, 1'b0, 4'h0, 1'b0, 64'd0};

	// Directed stream: zero-length frame and a stray byte, a reserved-bit error,
	// a masked frame with a 16-bit length, and a 64-bit length of all ones.
	localparam stim_row_t DIRECTED [27] = '{
		'{8'h81, 1'b0, 1'b1, '{ST_HEADER,   8'h00, 1'b0, 1'b1, 4'h1, 1'b0, 64'd0}},
		'{8'h00, 1'b0, 1'b1, '{ST_HEADER,   8'h00, 1'b1, 1'b1, 4'h1, 1'b0, 64'd0}},
		'{8'hFF, 1'b0, 1'b1, '{ST_REJECT,   8'h00, 1'b0, 1'b1, 4'h1, 1'b0, 64'd0}},
		'{8'h70, 1'b1, 1'b1, '{ST_HEADER,   8'h00, 1'b0, 1'b0, 4'h0, 1'b0, 64'd0}},
		'{8'hFF, 1'b0, 1'b1, '{ST_RESERVED, 8'h00, 1'b0, 1'b0, 4'h0, 1'b1, 64'd0}},
		'{8'h12, 1'b0, 1'b1, '{ST_REJECT,   8'h00, 1'b0, 1'b0, 4'h0, 1'b1, 64'd0}},
		'{8'h8F, 1'b1, 1'b1, '{ST_HEADER,   8'h00, 1'b0, 1'b1, 4'hF, 1'b0, 64'd0}},
		'{8'hFE, 1'b0, 1'b1, '{ST_HEADER,   8'h00, 1'b0, 1'b1, 4'hF, 1'b1, 64'd0}},
		'{8'h00, 1'b0, 1'b0, UNTYPED},
		'{8'h03, 1'b0, 1'b0, UNTYPED},
		'{8'hA5, 1'b0, 1'b0, UNTYPED},
		'{8'h5A, 1'b0, 1'b0, UNTYPED},
		'{8'hFF, 1'b0, 1'b0, UNTYPED},
		'{8'h00, 1'b0, 1'b0, UNTYPED},
		'{8'h00, 1'b0, 1'b0, UNTYPED},
		'{8'hFF, 1'b0, 1'b0, UNTYPED},
		'{8'h3C, 1'b0, 1'b0, UNTYPED},
		'{8'h02, 1'b1, 1'b1, '{ST_HEADER,   8'h00, 1'b0, 1'b0, 4'h2, 1'b0, 64'd0}},
		'{8'h7F, 1'b0, 1'b1, '{ST_HEADER,   8'h00, 1'b0, 1'b0, 4'h2, 1'b0, 64'd0}},
		'{8'hFF, 1'b0, 1'b0, UNTYPED},
		'{8'hFF, 1'b0, 1'b0, UNTYPED},
		'{8'hFF, 1'b0, 1'b0, UNTYPED},
		'{8'hFF, 1'b0, 1'b0, UNTYPED},
		'{8'hFF, 1'b0, 1'b0, UNTYPED},
		'{8'hFF, 1'b0, 1'b0, UNTYPED},
		'{8'hFF, 1'b0, 1'b0, UNTYPED},
		'{8'hFF, 1'b0, 1'b1,
			'{ST_HEADER, 8'h00, 1'b0, 1'b0, 4'h2, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF}}
	};

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  data_byte;
	logic        start_frame;
	logic        empty;
	logic        pop;
	logic [1:0]  status;
	logic [7:0]  data_out;
	logic        frame_done;
	logic        fin;
	logic [3:0]  opcode;
	logic        masked;
	logic [63:0] frame_len;

	// Parser state mirrored by the model.
	parse_phase_t ph;
	logic         hdr_second;
	logic         rsv_bad;
	logic         fin_q;
	logic [3:0]   op_q;
	logic         mask_q;
	logic [6:0]   code_q;
	logic [2:0]   ext_cnt;
	logic [63:0]  len_q;
	logic [63:0]  left_q;
	logic [31:0]  key_q;
	logic [1:0]   key_idx;

	frame_result_t result_q[$];
	int  errors = 0;
	int  words_in = 0;
	int  random_words = 0;
	int  results_checked = 0;
	int  frames_done = 0;
	int  reserved_seen = 0;
	int  rejects_seen = 0;
	int  cycle_count = 0;
	bit  idling_on = 1'b1;
	bit  hold_req = 1'b0;
	bit  hold_done = 1'b0;

	websocket_frame_parser dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.data_byte   (data_byte),
		.start_frame (start_frame),
		.empty       (empty),
		.pop         (pop),
		.status      (status),
		.data_out    (data_out),
		.frame_done  (frame_done),
		.fin         (fin),
		.opcode      (opcode),
		.masked      (masked),
		.frame_len   (frame_len)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Timeout guard.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("websocket_frame_parser test failed");
			$finish;
		end
	end

	// Return the model to its state after reset.
	function automatic void clear_parser();
		ph = P_HEADER;
		hdr_second = 1'b0;
		rsv_bad = 1'b0;
		fin_q = 1'b0;
		op_q = 4'h0;
		mask_q = 1'b0;
		code_q = 7'd0;
		ext_cnt = 3'd0;
		len_q = 64'd0;
		left_q = 64'd0;
		key_q = 32'd0;
		key_idx = 2'd0;
	endfunction

	// Step past a known length: go to the key, the payload, or finish.
	function automatic logic length_known(input logic key_pending);
		key_idx = 2'd0;
		if (key_pending) begin
			ph = P_KEY;
			return 1'b0;
		end
		if (left_q == 64'd0) begin
			ph = P_DONE;
			return 1'b1;
		end
		ph = P_PAYLOAD;
		return 1'b0;
	endfunction

	// Model of one input word: update the parser state, return the result word.
	function automatic frame_result_t parse_byte(input logic [7:0] b, input logic start);
		frame_result_t r;
		logic [7:0]    kb;
		int            need;
		r = UNTYPED;
		if (start)
			clear_parser();
		case (ph)
			P_HEADER: begin
				if (!hdr_second) begin
					fin_q = b[7];
					rsv_bad = |b[6:4];
					op_q = b[3:0];
					hdr_second = 1'b1;
				end else begin
					hdr_second = 1'b0;
					mask_q = b[7];
					code_q = b[6:0];
					if (rsv_bad) begin
						r.st = ST_RESERVED;
						ph = P_FAILED;
					end else if (code_q == LEN_CODE_16 || code_q == LEN_CODE_64) begin
						len_q = 64'd0;
						ext_cnt = 3'd0;
						ph = P_LENGTH;
					end else begin
						len_q = 64'(code_q);
						left_q = len_q;
						r.done = length_known(mask_q);
					end
				end
			end
			P_LENGTH: begin
				need = (code_q == LEN_CODE_16) ? 2 : 8;
				len_q = {len_q[55:0], b};
				if (int'(ext_cnt) + 1 >= need) begin
					ext_cnt = 3'd0;
					left_q = len_q;
					r.done = length_known(mask_q);
				end else begin
					ext_cnt = ext_cnt + 3'd1;
				end
			end
			P_KEY: begin
				key_q = {key_q[23:0], b};
				if (key_idx == 2'd3)
					r.done = length_known(1'b0);
				else
					key_idx = key_idx + 2'd1;
			end
			P_PAYLOAD: begin
				kb = mask_q ? key_q[8 * (3 - int'(key_idx)) +: 8] : NO_KEY;
				r.data = b ^ kb;
				r.st = ST_PAYLOAD;
				key_idx = key_idx + 2'd1;
				left_q = left_q - 64'd1;
				if (left_q == 64'd0) begin
					ph = P_DONE;
					r.done = 1'b1;
				end
			end
			default: begin
				r.st = ST_REJECT;
				ph = P_FAILED;
			end
		endcase
		r.fin = fin_q;
		r.op = op_q;
		r.masked = mask_q;
		r.len = len_q;
		return r;
	endfunction

	// Offer one word, wait for it to be taken, then queue its expected result.
	task automatic send_word(input logic [7:0] b, input logic s, input logic typed,
			input frame_result_t want, output wfp_status_t st);
		frame_result_t pred;
		int            gap;
		if (idling_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 5);
			repeat (gap) begin
				@(negedge clk);
				push <= 1'b0;
			end
		end
		@(negedge clk);
		push <= 1'b1;
		data_byte <= b;
		start_frame <= s;
		do @(posedge clk); while (full);
		pred = parse_byte(b, s);
		result_q.push_back(typed ? want : pred);
		st = pred.st;
		words_in++;
		if (pred.st != ST_REJECT)
			random_words++;
	endtask

	// One random frame: mostly well formed, sometimes cut short, with stray
	// trailing bytes, reserved bits, or just noise.
	task automatic send_random_frame();
		logic [7:0]  fb[$];
		logic [63:0] len;
		logic [6:0]  code;
		logic [7:0]  hdr0;
		logic        mk;
		logic        s0;
		int          pick;
		int          n_pay;
		int          cut;
		wfp_status_t st;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			repeat ($urandom_range(1, 4))
				send_word(8'($urandom), ($urandom_range(0, 3) == 0), 1'b0, UNTYPED, st);
			return;
		end
		hdr0 = 8'($urandom);
		if ($urandom_range(0, 9) != 0)
			hdr0[6:4] = 3'b000;
		mk = 1'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			code = 7'($urandom_range(0, 8));
			len = 64'(code);
		end else if (pick < 64) begin
			code = 7'($urandom_range(9, 125));
			len = 64'(code);
		end else if (pick < 78) begin
			code = LEN_CODE_16;
			len = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 65535))
				: 64'($urandom_range(0, 8));
		end else if (pick < 90) begin
			code = LEN_CODE_64;
			len = 64'($urandom_range(0, 8));
		end else begin
			code = LEN_CODE_64;
			len = {$urandom, $urandom};
		end
		fb.push_back(hdr0);
		fb.push_back({mk, code});
		if (code == LEN_CODE_16) begin
			fb.push_back(len[15:8]);
			fb.push_back(len[7:0]);
		end else if (code == LEN_CODE_64) begin
			for (int i = 7; i >= 0; i--)
				fb.push_back(len[8 * i +: 8]);
		end
		if (mk)
			repeat (4) fb.push_back(8'($urandom));
		// Long announced lengths are cut short; a start mark restarts the parser.
		n_pay = (len > 64'd125) ? $urandom_range(0, 6) : int'(len);
		repeat (n_pay) fb.push_back(8'($urandom));
		if ($urandom_range(0, 11) == 0) begin
			cut = $urandom_range(1, fb.size());
			while (fb.size() > cut)
				void'(fb.pop_back());
		end
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 2)) fb.push_back(8'($urandom));
		s0 = ($urandom_range(0, 19) != 0);
		foreach (fb[i])
			send_word(fb[i], (i == 0) ? s0 : 1'b0, 1'b0, UNTYPED, st);
	endtask

	// Receiver: random pop stalls, plus one long hold-off on request.
	initial begin : drive_pop
		int hold_left;
		int stall_left;
		hold_left = 0;
		stall_left = 0;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (idling_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 4);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Report one field mismatch.
	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	// Compare each popped result word with the oldest expectation.
	always @(posedge clk) begin : check_results
		frame_result_t want;
		if (arst_n && pop && !empty) begin
			if (result_q.size() == 0) begin
				$error("result word popped with nothing expected");
				errors++;
			end else begin
				want = result_q.pop_front();
				check_field("status", 64'(want.st), 64'(status));
				check_field("data_out", 64'(want.data), 64'(data_out));
				check_field("frame_done", 64'(want.done), 64'(frame_done));
				check_field("fin", 64'(want.fin), 64'(fin));
				check_field("opcode", 64'(want.op), 64'(opcode));
				check_field("masked", 64'(want.masked), 64'(masked));
				check_field("frame_len", want.len, frame_len);
				results_checked++;
				if (want.done)
					frames_done++;
				if (want.st == ST_RESERVED)
					reserved_seen++;
				if (want.st == ST_REJECT)
					rejects_seen++;
			end
		end
	end

	// Reset, directed table, random frames, drain and verdict.
	initial begin : run_stream
		wfp_status_t st;
		push = 1'b0;
		data_byte = 8'h00;
		start_frame = 1'b0;
		arst_n = 1'b0;
		clear_parser();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED[i])
			send_word(DIRECTED[i].b, DIRECTED[i].start, DIRECTED[i].typed,
				DIRECTED[i].want, st);

		random_words = 0;
		while (random_words < RANDOM_WORDS) begin
			// Hold the receiver off once so the internal queue fills and full rises.
			if (random_words >= 400 && !hold_done) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			if (random_words >= RANDOM_WORDS - 150)
				idling_on = 1'b0;
			send_random_frame();
		end
		@(negedge clk);
		push <= 1'b0;

		while (result_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d words, checked %0d results: %0d frames completed,",
			words_in, results_checked, frames_done);
		$display("%0d reserved-bit errors and %0d rejected bytes seen.",
			reserved_seen, rejects_seen);
		if (errors == 0) begin
			$display("websocket_frame_parser test passed");
		end else begin
			$display("websocket_frame_parser test failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/wfp_pkg.sv
rtl/core/wfp_front.sv
rtl/core/wfp_queue.sv
rtl/core/wfp_back.sv
rtl/core/websocket_frame_parser.sv
verif/websocket_frame_parser_tb.sv
